// ===== rtl/core/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg: shared types and constants for the SHA-1 hash core
// Initial value, round constants and the front-to-back word request format.
// ----------------------------------------------------------------------------
`default_nettype none
package sha1_pkg;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef logic [4:0][31:0] digest_t;

	localparam digest_t INIT_VALUE = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	// one block word for the back end; fin marks the final word of a message
	typedef struct packed {
		logic [31:0] word;
		logic        fin;
	} blk_word_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
		rotl = (x << s) | (x >> (32 - s));
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/sha1_if.sv =====
// ----------------------------------------------------------------------------
// sha1_in_if / sha1_out_if: valid/ready channels of the hash core
// Message word input and digest word output.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha1_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last_word;
	modport source (output valid, data_word, byte_count, last_word, input ready);
	modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_last;
	modport source (output valid, digest_word, digest_index, digest_last, input ready);
	modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sha1_front.sv =====
// ----------------------------------------------------------------------------
// sha1_front: message word intake and padding
// Counts the length, inserts pad, zero fill and length words into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module sha1_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	sha1_in_if.sink                in_ch,
	output sha1_pkg::blk_word_t    wq,
	output logic                   wq_valid,
	input  wire logic              wq_ready
);
	import sha1_pkg::*;

	typedef enum logic [3:0] {
		S_DATA = 4'b0001,
		S_ZERO = 4'b0010,
		S_LENH = 4'b0100,
		S_LENL = 4'b1000
	} st_t;

	st_t         st_q;
	logic [3:0]  pos_q;
	logic [63:0] len_q;
	logic        pad_pend_q;   // full last word taken, 0x80 word still owed
	logic [2:0]  cnt;
	logic [31:0] keep, padded;
	logic [63:0] len_next;

	always_comb begin
		cnt = (in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
		case (cnt)
			3'd0: keep = 32'h0;
			3'd1: keep = 32'hFF00_0000;
			3'd2: keep = 32'hFFFF_0000;
			3'd3: keep = 32'hFFFF_FF00;
			default: keep = 32'hFFFF_FFFF;
		endcase
		case (cnt)
			3'd0: padded = {PAD_BYTE, 24'h0};
			3'd1: padded = (in_ch.data_word & keep) | {8'h0, PAD_BYTE, 16'h0};
			3'd2: padded = (in_ch.data_word & keep) | {16'h0, PAD_BYTE, 8'h0};
			3'd3: padded = (in_ch.data_word & keep) | {24'h0, PAD_BYTE};
			default: padded = in_ch.data_word;
		endcase
		len_next = len_q + (in_ch.last_word ? {58'h0, cnt, 3'b000} : 64'd32);
	end

	assign in_ch.ready = (st_q == S_DATA) && !pad_pend_q && wq_ready;

	always_comb begin
		wq_valid = 1'b0;
		wq.word  = 32'h0;
		wq.fin   = 1'b0;
		case (st_q)
			S_DATA: begin
				if (pad_pend_q) begin
					wq_valid = 1'b1;
					wq.word  = {PAD_BYTE, 24'h0};
				end else begin
					wq_valid = in_ch.valid;
					wq.word  = in_ch.last_word ? padded : in_ch.data_word;
				end
			end
			S_ZERO: wq_valid = 1'b1;
			S_LENH: begin
				wq_valid = 1'b1;
				wq.word  = len_q[63:32];
			end
			S_LENL: begin
				wq_valid = 1'b1;
				wq.word  = len_q[31:0];
				wq.fin   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_DATA;
			pos_q      <= 4'd0;
			len_q      <= 64'd0;
			pad_pend_q <= 1'b0;
		end else if (wq_valid && wq_ready) begin
			pos_q <= pos_q + 4'd1;
			case (st_q)
				S_DATA: begin
					if (pad_pend_q) begin
						pad_pend_q <= 1'b0;
						st_q <= (pos_q == 4'd13) ? S_LENH : S_ZERO;
					end else begin
						len_q <= len_next;
						if (in_ch.last_word) begin
							if (cnt == 3'd4) pad_pend_q <= 1'b1;
							else st_q <= (pos_q == 4'd13) ? S_LENH : S_ZERO;
						end
					end
				end
				S_ZERO: if (pos_q == 4'd13) st_q <= S_LENH;
				S_LENH: st_q <= S_LENL;
				S_LENL: begin
					st_q  <= S_DATA;
					len_q <= 64'd0;
				end
				default: st_q <= S_DATA;
			endcase
		end
	end

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_LENL |-> pos_q == 4'd15) else $error("length low not at slot 15");
	a_lenh_pos: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_LENH |-> pos_q == 4'd14) else $error("length high not at slot 14");
	a_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != S_DATA |-> !in_ch.ready) else $error("input taken during padding");
endmodule
`default_nettype wire

// ===== rtl/core/sha1_queue.sv =====
// ----------------------------------------------------------------------------
// sha1_queue: small word queue between front and back
// Two-entry FIFO so either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none
module sha1_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  sha1_pkg::blk_word_t wr_data,
	input  wire logic           wr_valid,
	output logic                wr_ready,
	output sha1_pkg::blk_word_t rd_data,
	output logic                rd_valid,
	input  wire logic           rd_ready
);
	import sha1_pkg::*;

	blk_word_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count overrun");
endmodule
`default_nettype wire

// ===== rtl/core/sha1_back.sv =====
// ----------------------------------------------------------------------------
// sha1_back: SHA-1 compression and digest output
// Fills the block, runs 80 rounds one per cycle, emits five digest words.
// ----------------------------------------------------------------------------
`default_nettype none
module sha1_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  sha1_pkg::blk_word_t wq,
	input  wire logic           wq_valid,
	output logic                wq_ready,
	sha1_out_if.source          out_ch
);
	import sha1_pkg::*;

	typedef enum logic [2:0] {
		B_FILL  = 3'b001,
		B_ROUND = 3'b010,
		B_OUT   = 3'b100
	} bst_t;

	bst_t             st_q;
	logic [15:0][31:0] sched_q;
	logic [3:0]       pos_q;
	logic [6:0]       rnd_q;
	logic             fin_q;
	logic [2:0]       idx_q;
	digest_t          cv_q;
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;
	logic [3:0]       slot;
	logic [31:0]      w, f, k, t;
	logic [4:0]       grp;

	assign wq_ready = (st_q == B_FILL);
	assign slot     = rnd_q[3:0];

	always_comb begin
		if (rnd_q < 7'd16) w = sched_q[slot];
		else w = rotl(sched_q[slot + 4'd13] ^ sched_q[slot + 4'd8]
			^ sched_q[slot + 4'd2] ^ sched_q[slot], 1);
		grp = 5'd0;
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t = rotl(a_q, 5) + f + e_q + w + k + {27'h0, grp};
	end

	assign out_ch.valid        = (st_q == B_OUT);
	assign out_ch.digest_word  = cv_q[idx_q];
	assign out_ch.digest_index = idx_q;
	assign out_ch.digest_last  = (idx_q == 3'd4);

	always_ff @(posedge clk) begin
		case (st_q)
			B_FILL: if (wq_valid) begin
				sched_q[pos_q] <= wq.word;
				if (pos_q == 4'd15) begin
					{a_q, b_q, c_q, d_q, e_q} <= {cv_q[0], cv_q[1], cv_q[2], cv_q[3], cv_q[4]};
				end
			end
			B_ROUND: begin
				sched_q[slot] <= w;
				e_q <= d_q;
				d_q <= c_q;
				c_q <= rotl(b_q, 30);
				b_q <= a_q;
				a_q <= t;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_FILL;
			pos_q <= 4'd0;
			rnd_q <= 7'd0;
			fin_q <= 1'b0;
			idx_q <= 3'd0;
			cv_q  <= INIT_VALUE;
		end else begin
			case (st_q)
				B_FILL: if (wq_valid) begin
					pos_q <= pos_q + 4'd1;
					if (pos_q == 4'd15) begin
						fin_q <= wq.fin;
						rnd_q <= 7'd0;
						st_q  <= B_ROUND;
					end
				end
				B_ROUND: begin
					if (rnd_q == 7'd79) begin
						// fold the last round straight into the chaining value
						cv_q[0] <= cv_q[0] + t;
						cv_q[1] <= cv_q[1] + a_q;
						cv_q[2] <= cv_q[2] + rotl(b_q, 30);
						cv_q[3] <= cv_q[3] + c_q;
						cv_q[4] <= cv_q[4] + d_q;
						idx_q   <= 3'd0;
						st_q    <= fin_q ? B_OUT : B_FILL;
					end
					rnd_q <= rnd_q + 7'd1;
				end
				B_OUT: if (out_ch.ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd4) begin
						cv_q <= INIT_VALUE;
						st_q <= B_FILL;
					end
				end
				default: st_q <= B_FILL;
			endcase
		end
	end

	a_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_ROUND |-> rnd_q < 7'd80) else $error("round count overrun");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_OUT |-> idx_q <= 3'd4) else $error("digest index overrun");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != B_FILL |-> pos_q == 4'd0) else $error("block not aligned");
endmodule
`default_nettype wire

// ===== rtl/core/sha1_hash_core.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_core: streaming SHA-1 digest engine
// Pads the message, compresses each 512-bit block, emits five digest words.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_ch   | in  | data_word[31:0], byte_count[2:0], last_word
// out_ch  | out | digest_word[31:0], digest_index[2:0], digest_last
//
// A block is filled with 16 words, then runs 80 rounds, one round a cycle;
// the back end takes no new word while its rounds run.
// The last word fills out its block with padding, plus one more block when
// the pad lands in slot 14 or 15, then emits five digest words.
// Reset restores the initial value; both channels stall independently
// through a two-entry word queue.
`default_nettype none
module sha1_hash_core (
	input  wire logic clk,
	input  wire logic arst_n,
	sha1_in_if.sink   in_ch,
	sha1_out_if.source out_ch
);
	import sha1_pkg::*;

	blk_word_t fw, bw;
	logic      fv, fr, bv, br;

	sha1_front u_front (.clk, .arst_n, .in_ch, .wq(fw), .wq_valid(fv), .wq_ready(fr));
	sha1_queue u_queue (.clk, .arst_n, .wr_data(fw), .wr_valid(fv), .wr_ready(fr),
		.rd_data(bw), .rd_valid(bv), .rd_ready(br));
	sha1_back u_back (.clk, .arst_n, .wq(bw), .wq_valid(bv), .wq_ready(br), .out_ch);
endmodule
`default_nettype wire
